>>> sv/bmhq_pkg.sv
// -----------------------------------------------------------------------------
// bmhq_pkg: shared types and codes of the binary max-heap queue
// Operation and status codes and the result record handed between the
// heap sequencer and the output register.
// -----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;

	// operation codes carried in func
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// status codes of a result
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		value_t                popped_value;
		value_t                top_value;
		logic [COUNT_W-1:0]    entry_count;
		logic [STATUS_W-1:0]   status;
	} result_t;

endpackage

>>> sv/bmhq_if.sv
// -----------------------------------------------------------------------------
// bmhq_if: valid/ready channels of the binary max-heap queue
// bmhq_cmd_if carries operations in, bmhq_res_if carries results out.
// -----------------------------------------------------------------------------
interface bmhq_cmd_if;
	logic              valid;
	logic              ready;
	logic              func;
	bmhq_pkg::value_t  value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

interface bmhq_res_if;
	logic                                valid;
	logic                                ready;
	bmhq_pkg::value_t                    popped_value;
	bmhq_pkg::value_t                    top_value;
	logic [bmhq_pkg::COUNT_W-1:0]        entry_count;
	logic [bmhq_pkg::STATUS_W-1:0]       status;

	modport source (output valid, output popped_value, output top_value,
		output entry_count, output status, input ready);
	modport sink   (input valid, input popped_value, input top_value,
		input entry_count, input status, output ready);
endinterface

>>> sv/binary_max_heap_queue.sv
// -----------------------------------------------------------------------------
// binary_max_heap_queue: max-priority queue of signed 32-bit values
// Array binary heap in one memory, maintained by a small sequencer that
// reuses a single signed comparator for every sift step.
// -----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation per transaction: func 0 pushes value, func 1
//   pops the largest entry. res returns one result per operation: the popped
//   value (0 on push or empty), the top after the operation (0 when empty),
//   the entry count and a status (ok, pop on empty, push dropped when full).
//   One operation is in flight at a time; cmd.ready is low while it runs.
//   Each operation runs as a sequence of sequencer steps: a pop on empty, a
//   push on full or a pop of the last entry goes straight to the result; a
//   push compares the value with each parent in turn, moving the parent
//   down, until it reaches the root or stops below a parent not smaller;
//   any other pop moves the last entry to the root and sinks it, reading
//   the left and, where it exists, the right child of each level, until it
//   stops or reaches a leaf. The sift loop with its single memory read
//   port sets the latency. cmd.ready returns as the result enters the output register.
//   A finished result sits in an output register; the next operation is
//   accepted while it waits. If the receiver still stalls when the next
//   result is done, the sequencer holds that result until the register frees.
//   Reset empties the queue at once; memory contents are never cleared, only
//   entries below the count are read.
// -----------------------------------------------------------------------------
module binary_max_heap_queue #(
	parameter int QUEUE_DEPTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	bmhq_cmd_if.sink   cmd,
	bmhq_res_if.source res
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int KW = AW + 2;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_UP_RD   = 9'b000000010,
		S_UP_CMP  = 9'b000000100,
		S_DN_LAST = 9'b000001000,
		S_DN_RDR  = 9'b000010000,
		S_DN_SEL  = 9'b000100000,
		S_DN_DEC  = 9'b001000000,
		S_FIN     = 9'b010000000,
		S_RESP    = 9'b100000000
	} state_t;

	state_t                         state_q;
	logic [CW-1:0]                  count_q;
	logic [AW-1:0]                  pos_q;
	logic [AW-1:0]                  kid_q;
	logic [AW-1:0]                  child_idx_q;
	bmhq_pkg::value_t               v_q;
	bmhq_pkg::value_t               left_q;
	bmhq_pkg::value_t               child_q;
	bmhq_pkg::value_t               root_q;
	bmhq_pkg::value_t               popped_q;
	logic [bmhq_pkg::STATUS_W-1:0]  status_q;

	// heap memory, one write and one registered read per cycle
	bmhq_pkg::value_t               mem [QUEUE_DEPTH];
	bmhq_pkg::value_t               rdata_q;
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr;
	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	bmhq_pkg::value_t               wr_data;

	// shared comparator
	bmhq_pkg::value_t               cmp_a;
	bmhq_pkg::value_t               cmp_b;
	logic                           cmp_lt;

	logic                           accept;
	logic                           full;
	logic [CW-1:0]                  last_idx;
	logic [AW-1:0]                  parent_idx;
	logic [KW-1:0]                  cnt_ext;
	logic                           right_exists;
	logic [KW-1:0]                  next_kid;
	logic                           next_kid_ok;
	logic                           out_load;
	logic                           out_can_load;
	bmhq_pkg::result_t              out_data;

	assign accept       = cmd.valid && cmd.ready;
	assign cmd.ready    = (state_q == S_IDLE);
	assign full         = (count_q == CW'(QUEUE_DEPTH));
	assign last_idx     = count_q - CW'(1);
	assign parent_idx   = (pos_q - AW'(1)) >> 1;
	assign cnt_ext      = KW'(count_q);
	assign right_exists = (KW'(kid_q) + KW'(1)) < cnt_ext;
	assign next_kid     = (KW'(child_idx_q) << 1) + KW'(1);
	assign next_kid_ok  = next_kid < cnt_ext;

	// pick comparator operands: a < b
	always_comb begin
		unique case (state_q)
			S_UP_CMP: begin
				cmp_a = rdata_q;
				cmp_b = v_q;
			end
			S_DN_SEL: begin
				cmp_a = left_q;
				cmp_b = rdata_q;
			end
			default: begin
				cmp_a = v_q;
				cmp_b = child_q;
			end
		endcase
	end
	assign cmp_lt = cmp_a < cmp_b;

	// drive memory ports from the sequencer state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = v_q;
		unique case (state_q)
			S_IDLE: begin
				rd_en   = accept && (cmd.func == bmhq_pkg::FUNC_POP) && (count_q > CW'(1));
				rd_addr = last_idx[AW-1:0];
			end
			S_UP_RD: begin
				wr_en   = (pos_q == '0);
				rd_en   = (pos_q != '0);
				rd_addr = parent_idx;
			end
			S_UP_CMP: begin
				wr_en   = 1'b1;
				wr_data = cmp_lt ? rdata_q : v_q;
			end
			S_DN_LAST: begin
				wr_en   = (count_q == CW'(1));
				wr_addr = '0;
				wr_data = rdata_q;
				rd_en   = (count_q > CW'(1));
				rd_addr = AW'(1);
			end
			S_DN_RDR: begin
				rd_en   = right_exists;
				rd_addr = kid_q + AW'(1);
			end
			S_DN_DEC: begin
				wr_en   = 1'b1;
				wr_data = cmp_lt ? child_q : v_q;
				rd_en   = cmp_lt && next_kid_ok;
				rd_addr = next_kid[AW-1:0];
			end
			S_FIN: begin
				wr_en   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// mirror the root for top_value
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == '0)) begin
			root_q <= wr_data;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.func == bmhq_pkg::FUNC_PUSH) begin
							if (full) begin
								state_q <= S_RESP;
							end else begin
								count_q <= count_q + CW'(1);
								state_q <= S_UP_RD;
							end
						end else begin
							if (count_q == '0) begin
								state_q <= S_RESP;
							end else begin
								count_q <= last_idx;
								state_q <= (count_q == CW'(1)) ? S_RESP : S_DN_LAST;
							end
						end
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_RESP : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= cmp_lt ? S_UP_RD : S_RESP;
				end
				S_DN_LAST: begin
					state_q <= (count_q > CW'(1)) ? S_DN_RDR : S_RESP;
				end
				S_DN_RDR: begin
					state_q <= right_exists ? S_DN_SEL : S_DN_DEC;
				end
				S_DN_SEL: begin
					state_q <= S_DN_DEC;
				end
				S_DN_DEC: begin
					if (!cmp_lt) begin
						state_q <= S_RESP;
					end else if (next_kid_ok) begin
						state_q <= S_DN_RDR;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// sift datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				popped_q <= '0;
				status_q <= bmhq_pkg::ST_OK;
				pos_q    <= count_q[AW-1:0];
				v_q      <= cmd.value;
				if (cmd.func == bmhq_pkg::FUNC_PUSH) begin
					if (full) begin
						status_q <= bmhq_pkg::ST_FULL;
					end
				end else if (count_q == '0) begin
					status_q <= bmhq_pkg::ST_EMPTY;
				end else begin
					popped_q <= root_q;
				end
			end
			S_UP_CMP: begin
				if (cmp_lt) begin
					pos_q <= parent_idx;
				end
			end
			S_DN_LAST: begin
				v_q   <= rdata_q;
				pos_q <= '0;
				kid_q <= AW'(1);
			end
			S_DN_RDR: begin
				left_q      <= rdata_q;
				child_q     <= rdata_q;
				child_idx_q <= kid_q;
			end
			S_DN_SEL: begin
				if (cmp_lt) begin
					child_q     <= rdata_q;
					child_idx_q <= kid_q + AW'(1);
				end
			end
			S_DN_DEC: begin
				if (cmp_lt) begin
					pos_q <= child_idx_q;
					kid_q <= next_kid[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// assemble the result
	assign out_load                = (state_q == S_RESP);
	assign out_data.popped_value   = popped_q;
	assign out_data.top_value      = (count_q == '0) ? '0 : root_q;
	assign out_data.entry_count    = (bmhq_pkg::COUNT_W)'(count_q);
	assign out_data.status         = status_q;

	bmhq_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.data     (out_data),
		.can_load (out_can_load),
		.res      (res)
	);

endmodule

>>> sv/bmhq_out_stage.sv
// -----------------------------------------------------------------------------
// bmhq_out_stage: result register of the heap queue
// Holds one finished result until the receiver takes the transaction, so the
// sequencer can accept the next operation while a result still waits.
// -----------------------------------------------------------------------------
module bmhq_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  bmhq_pkg::result_t  data,
	output logic               can_load,
	bmhq_res_if.source         res
);

	logic               valid_q;
	bmhq_pkg::result_t  data_q;

	// free when empty or being drained this cycle
	assign can_load = !valid_q || res.ready;

	// track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load && can_load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// capture payload
	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= data;
		end
	end

	assign res.valid        = valid_q;
	assign res.popped_value = data_q.popped_value;
	assign res.top_value    = data_q.top_value;
	assign res.entry_count  = data_q.entry_count;
	assign res.status       = data_q.status;

endmodule

>>> sv/bmhq_checker.sv
// -----------------------------------------------------------------------------
// bmhq_checker: port-level checks of the binary max-heap queue
// Watches the command and result channels and flags results that contradict
// the queue's rules; bound to every instance of the top level.
// -----------------------------------------------------------------------------
module bmhq_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cmd_valid,
	input logic                                cmd_ready,
	input logic                                res_valid,
	input logic                                res_ready,
	input bmhq_pkg::value_t                    popped_value,
	input bmhq_pkg::value_t                    top_value,
	input logic [bmhq_pkg::COUNT_W-1:0]        entry_count,
	input logic [bmhq_pkg::STATUS_W-1:0]       status
);

	// a stalled result holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(popped_value)
			&& $stable(top_value) && $stable(entry_count) && $stable(status))
		else $error("result changed while stalled");

	// one operation at a time: busy right after a command transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while an operation runs");

	// pop on empty reports an empty queue and no value
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == bmhq_pkg::ST_EMPTY) |->
			(entry_count == '0) && (popped_value == '0) && (top_value == '0))
		else $error("empty pop result inconsistent");

	// a dropped push result never carries a popped value and has a nonzero count
	a_push_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == bmhq_pkg::ST_FULL) |-> (popped_value == '0)
			&& (entry_count != '0))
		else $error("dropped push result inconsistent");

	// a valid status is one of the defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (status == bmhq_pkg::ST_OK) || (status == bmhq_pkg::ST_EMPTY)
			|| (status == bmhq_pkg::ST_FULL))
		else $error("undefined status code");

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.popped_value (res.popped_value),
	.top_value    (res.top_value),
	.entry_count  (res.entry_count),
	.status       (res.status)
);
